>>> hdl/mbet_pkg.sv
// ----------------------------------------------------------------------------
// mbet_pkg: shared types and constants for the Mandelbrot escape-time block
// Field widths, register indexes and reset values, and the command/status
// bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package mbet_pkg;

   localparam int IDX_W     = 12;   // row / column index
   localparam int STEP_W    = 29;   // real_step / imag_step
   localparam int ITER_W    = 16;   // max_iter / escape_count
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   localparam logic [CSR_IDX_W-1:0] CSR_MAX_ITER  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REAL_STEP = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_IMAG_STEP = 2'd2;

   localparam logic [ITER_W-1:0] MAX_ITER_RESET = 16'd256;
   localparam logic [STEP_W-1:0] STEP_RESET     = 29'd262144;

   typedef struct packed {
      logic capture;   // latch clamped indexes of an accepted request
      logic coord;     // index * step products
      logic init;      // form c, clear z and k
      logic mul;       // squares and cross product of z
      logic update;    // new z, k + 1, escape tests
      logic emit;      // move result into the output register
   } mbet_cmd_type;

   typedef struct packed {
      logic finish;    // valid with cmd.update: iteration loop ends
   } mbet_sts_type;

endpackage

>>> hdl/mbet_dpath.sv
// ----------------------------------------------------------------------------
// mbet_dpath: escape-time datapath
// Coordinate products, z registers, three multipliers for z_r^2,
// z_i^2 and 2*z_r*z_i, the escape tests and the result registers.
// ----------------------------------------------------------------------------
module mbet_dpath #(
   parameter int INDEX_LIMIT = 4096,
   parameter int FRAC_BITS   = 26
) (
   input  logic                          clock,
   input  mbet_pkg::mbet_cmd_type        cmd,
   output mbet_pkg::mbet_sts_type        sts,
   input  logic [mbet_pkg::IDX_W-1:0]    row_index,
   input  logic [mbet_pkg::IDX_W-1:0]    col_index,
   input  logic [mbet_pkg::ITER_W-1:0]   max_iter,
   input  logic [mbet_pkg::STEP_W-1:0]   real_step,
   input  logic [mbet_pkg::STEP_W-1:0]   imag_step,
   output logic [mbet_pkg::ITER_W-1:0]   escape_count
);
   import mbet_pkg::*;

   localparam int ZW     = FRAC_BITS + 2;          // z while each coordinate is below 2 in magnitude
   localparam int PW     = FRAC_BITS + 4;          // truncated products
   localparam int PROD_W = IDX_W + STEP_W;         // index * step
   localparam int NW     = ((PROD_W > FRAC_BITS + 2) ? PROD_W : FRAC_BITS + 2) + 3;

   localparam logic signed [NW-1:0]   TWO_Q     = NW'(2) << FRAC_BITS;
   localparam logic signed [NW-1:0]   NEG_TWO_Q = -TWO_Q;
   localparam logic signed [PW:0]     FOUR_Q    = (PW + 1)'(4) << FRAC_BITS;
   localparam logic [31:0]            LIMIT     = 32'(INDEX_LIMIT);

   logic [IDX_W-1:0]         row_ff, col_ff, row_in, col_in;
   logic [PROD_W-1:0]        rprod_ff, iprod_ff;
   logic signed [NW-1:0]     cr_ff, ci_ff, zr_ff, zi_ff;
   logic signed [NW-1:0]     cr_in, ci_in, nr_in, ni_in;
   logic signed [PW-1:0]     sqr_ff, sqi_ff, crs_ff;
   logic [ITER_W-1:0]        k_ff, res_ff, res_in, count_ff;

   logic signed [ZW-1:0]     zr_m, zi_m;
   logic signed [ZW:0]       zr2_m;
   logic signed [2*ZW-1:0]   p_rr, p_ii;
   logic signed [2*ZW:0]     p_ri;
   logic signed [PW:0]       sq_sum;
   logic [ITER_W:0]          k_next;
   logic                     sum_esc, mag_esc, reached;

   // indexes past the limit clamp to the last one
   assign row_in = (32'(row_index) >= LIMIT) ? IDX_W'(LIMIT - 32'd1) : row_index;
   assign col_in = (32'(col_index) >= LIMIT) ? IDX_W'(LIMIT - 32'd1) : col_index;

   assign cr_in = $signed(NW'(rprod_ff)) - TWO_Q;
   assign ci_in = TWO_Q - $signed(NW'(iprod_ff));

   // z is only multiplied while each coordinate is below 2 in magnitude, so the low bits carry it exactly
   assign zr_m  = zr_ff[ZW-1:0];
   assign zi_m  = zi_ff[ZW-1:0];
   assign zr2_m = {zr_m, 1'b0};
   assign p_rr  = zr_m * zr_m;
   assign p_ii  = zi_m * zi_m;
   assign p_ri  = zr2_m * zi_m;

   assign nr_in = NW'(sqr_ff) - NW'(sqi_ff) + cr_ff;
   assign ni_in = NW'(crs_ff) + ci_ff;

   // squares of the current z: escape test for the previous update
   assign sq_sum  = (PW + 1)'(sqr_ff) + (PW + 1)'(sqi_ff);
   assign sum_esc = (sq_sum >= FOUR_Q);
   assign k_next  = (ITER_W + 1)'(k_ff) + (ITER_W + 1)'(1);
   assign reached = (k_next >= {1'b0, max_iter});
   assign mag_esc = (nr_in >= TWO_Q) || (ni_in >= TWO_Q) ||
                    (nr_in <= NEG_TWO_Q) || (ni_in <= NEG_TWO_Q);

   assign sts.finish = sum_esc || reached || mag_esc;

   always_comb begin
      if (sum_esc) begin
         res_in = k_ff;
      end else if (reached) begin
         res_in = '0;
      end else begin
         res_in = k_next[ITER_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
      if (cmd.coord) begin
         rprod_ff <= PROD_W'(col_ff) * PROD_W'(real_step);
         iprod_ff <= PROD_W'(row_ff) * PROD_W'(imag_step);
      end
      if (cmd.init) begin
         cr_ff <= cr_in;
         ci_ff <= ci_in;
         zr_ff <= '0;
         zi_ff <= '0;
         k_ff  <= '0;
      end
      if (cmd.mul) begin
         sqr_ff <= p_rr[FRAC_BITS +: PW];
         sqi_ff <= p_ii[FRAC_BITS +: PW];
         crs_ff <= p_ri[FRAC_BITS +: PW];
      end
      if (cmd.update) begin
         zr_ff  <= nr_in;
         zi_ff  <= ni_in;
         k_ff   <= k_next[ITER_W-1:0];
         res_ff <= res_in;
      end
      if (cmd.emit) begin
         count_ff <= res_ff;
      end
   end

   assign escape_count = count_ff;

endmodule

>>> hdl/mbet_ctrl.sv
// ----------------------------------------------------------------------------
// mbet_ctrl: escape-time controller
// Sequences one request through coordinate setup and the multiply/update
// loop, and owns the request stall and the result valid.
// ----------------------------------------------------------------------------
module mbet_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output mbet_pkg::mbet_cmd_type  cmd,
   input  mbet_pkg::mbet_sts_type  sts
);
   import mbet_pkg::*;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_COORD = 6'b000010,
      ST_INIT  = 6'b000100,
      ST_MUL   = 6'b001000,
      ST_UPD   = 6'b010000,
      ST_DONE  = 6'b100000
   } mbet_state_type;

   mbet_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      cmd         = '0;
      state_in    = state_ff;
      case (state_ff)
         ST_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) begin
               state_in = ST_COORD;
            end
         end
         ST_COORD: begin
            cmd.coord = 1'b1;
            state_in  = ST_INIT;
         end
         ST_INIT: begin
            cmd.init = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_UPD;
         end
         ST_UPD: begin
            cmd.update = 1'b1;
            state_in   = sts.finish ? ST_DONE : ST_MUL;
         end
         ST_DONE: begin
            cmd.emit = slot_free;
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

endmodule

>>> hdl/mandelbrot_escape_time.sv
// ----------------------------------------------------------------------------
// mandelbrot_escape_time: escape-time count for one pixel
// One request carries a pixel's row and column; one response carries the
// number of iterations of z = z*z + c until |z|^2 >= 4, or zero when the
// limit max_iter is reached. c = (-2 + col*real_step) + i*(2 - row*imag_step),
// all in signed fixed point with FRAC_BITS fraction bits, products truncated.
// Each iteration is one multiply step (three multipliers for z_r^2, z_i^2
// and 2*z_r*z_i) and one update step. Setup of c comes before the loop;
// after it come, for an escape found by |z|^2 >= 4, a closing pass that
// tests the squares of the last z, and then the move into the output
// register. A coordinate of z that reaches magnitude two ends the loop at
// once. One request is in work at a time; a finished count waits in the
// output register while the next request is accepted. The user must write
// registers through the csr port only while the block is idle; the block
// itself does not enforce it.
// ----------------------------------------------------------------------------
module mandelbrot_escape_time #(
   parameter int INDEX_LIMIT = 4096,
   parameter int FRAC_BITS   = 26
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [mbet_pkg::IDX_W-1:0]       req_row_index,
   input  logic [mbet_pkg::IDX_W-1:0]       req_col_index,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [mbet_pkg::ITER_W-1:0]      rsp_escape_count,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mbet_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mbet_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import mbet_pkg::*;

   mbet_cmd_type        cmd;
   mbet_sts_type        sts;
   logic [ITER_W-1:0]   max_iter_ff;
   logic [STEP_W-1:0]   real_step_ff, imag_step_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_iter_ff  <= MAX_ITER_RESET;
         real_step_ff <= STEP_RESET;
         imag_step_ff <= STEP_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MAX_ITER:  max_iter_ff  <= csr_wdata[ITER_W-1:0];
            CSR_REAL_STEP: real_step_ff <= csr_wdata[STEP_W-1:0];
            CSR_IMAG_STEP: imag_step_ff <= csr_wdata[STEP_W-1:0];
            default: begin
               // unmapped index: write dropped
            end
         endcase
      end
   end

   mbet_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd),
      .sts       (sts)
   );

   mbet_dpath #(
      .INDEX_LIMIT (INDEX_LIMIT),
      .FRAC_BITS   (FRAC_BITS)
   ) u_dpath (
      .clock        (clock),
      .cmd          (cmd),
      .sts          (sts),
      .row_index    (req_row_index),
      .col_index    (req_col_index),
      .max_iter     (max_iter_ff),
      .real_step    (real_step_ff),
      .imag_step    (imag_step_ff),
      .escape_count (rsp_escape_count)
   );

endmodule

>>> verif/tb_mandelbrot_escape_time.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mandelbrot_escape_time: self-checking bench for the escape-time block
// A directed table covers the corners of the plane, fixed points inside the
// set and the iteration limit extremes. Random phases then reprogram the limit
// and both steps and sweep pixel grids. Every response is checked, against
// a fixed-point model of the iteration where the table gives no count, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb_mandelbrot_escape_time;
   import mbet_pkg::*;

   localparam int INDEX_LIMIT  = 4096;
   localparam int FRAC_BITS    = 26;
   localparam int RANDOM_ITEMS = 1700;
   localparam int CYCLE_LIMIT  = 20_000_000;
   localparam int TAIL_CYCLES  = 64;
   localparam int REPORT_MAX   = 10;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   localparam longint FX_TWO  = longint'(2) << FRAC_BITS;
   localparam longint FX_FOUR = longint'(4) << FRAC_BITS;

   typedef struct packed {
      logic [ITER_W-1:0] limit;
      logic [IDX_W-1:0]  row;
      logic [IDX_W-1:0]  col;
      logic              typed;   // count below is known, model not used
      logic [ITER_W-1:0] count;
   } pixel_vec_type;

   // default steps are 1/256 per index: c = 0 at (512, 512)
   localparam int NUM_DIRECTED = 23;
   localparam pixel_vec_type DIRECTED [NUM_DIRECTED] = '{
      '{16'd256,   12'd0,     12'd0,     1'b1, 16'd1},   // -2+2i, coordinates of magnitude 2
      '{16'd256,   12'd4095,  12'd4095,  1'b1, 16'd1},
      '{16'd256,   12'd0,     12'd4095,  1'b1, 16'd1},
      '{16'd256,   12'd4095,  12'd0,     1'b1, 16'd1},
      '{16'd256,   12'd512,   12'd0,     1'b1, 16'd1},   // c = -2
      '{16'd256,   12'd0,     12'd512,   1'b1, 16'd1},   // c = 2i
      '{16'd256,   12'd512,   12'd512,   1'b1, 16'd0},   // origin
      '{16'd256,   12'd512,   12'd256,   1'b1, 16'd0},   // c = -1, period two
      '{16'd256,   12'd256,   12'd512,   1'b0, 16'd0},   // c = i
      '{16'd256,   12'd512,   12'd576,   1'b0, 16'd0},   // c = 0.25, cusp
      '{16'd256,   12'd512,   12'd640,   1'b0, 16'd0},
      '{16'd256,   12'hAAA,   12'h555,   1'b0, 16'd0},
      '{16'd256,   12'h555,   12'hAAA,   1'b0, 16'd0},
      '{16'd256,   12'd400,   12'd350,   1'b0, 16'd0},
      '{16'd0,     12'd512,   12'd512,   1'b1, 16'd0},   // limit zero
      '{16'd0,     12'd0,     12'd0,     1'b1, 16'd0},
      '{16'd1,     12'd0,     12'd0,     1'b1, 16'd0},   // limit one
      '{16'd1,     12'd700,   12'd300,   1'b1, 16'd0},
      '{16'd2,     12'd0,     12'd0,     1'b1, 16'd1},
      '{16'd2,     12'd512,   12'd512,   1'b1, 16'd0},
      '{16'd65535, 12'd512,   12'd512,   1'b1, 16'd0},   // full-length loop
      '{16'd65535, 12'd0,     12'd0,     1'b1, 16'd1},
      '{16'd65535, 12'd512,   12'd640,   1'b0, 16'd0}
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic [IDX_W-1:0]     req_row_index;
   logic [IDX_W-1:0]     req_col_index;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic [ITER_W-1:0]    rsp_escape_count;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_DAT_W-1:0] csr_wdata;

   // shadow copy of the block's registers
   logic [ITER_W-1:0]    cfg_max_iter  = MAX_ITER_RESET;
   logic [STEP_W-1:0]    cfg_real_step = STEP_RESET;
   logic [STEP_W-1:0]    cfg_imag_step = STEP_RESET;

   logic [ITER_W-1:0]    escape_q [$];
   int unsigned          sent_count     = 0;
   int unsigned          checked_count  = 0;
   int unsigned          mismatch_count = 0;
   int unsigned          phase_count    = 0;
   int unsigned          cycle_count    = 0;
   bit                   req_quiet      = 1'b0;
   bit                   rsp_quiet      = 1'b0;

   mandelbrot_escape_time #(
      .INDEX_LIMIT(INDEX_LIMIT),
      .FRAC_BITS  (FRAC_BITS)
   ) u_top (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_row_index   (req_row_index),
      .req_col_index   (req_col_index),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_escape_count(rsp_escape_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always #4 clock = ~clock;

   // exact product, then floor shift back to the fixed-point scale
   function automatic longint fx_mul(input longint a, input longint b);
      logic signed [127:0] wa;
      logic signed [127:0] wb;
      logic signed [127:0] prod;
      wa = a;
      wb = b;
      prod = (wa * wb) >>> FRAC_BITS;
      return prod[63:0];
   endfunction

   function automatic longint fx_abs(input longint v);
      return (v < 0) ? -v : v;
   endfunction

   function automatic logic [ITER_W-1:0] predict_escape(input logic [IDX_W-1:0] row,
                                                        input logic [IDX_W-1:0] col);
      longint      r_idx;
      longint      c_idx;
      longint      step_r;
      longint      step_i;
      longint      cr;
      longint      ci;
      longint      zr;
      longint      zi;
      longint      nr;
      longint      ni;
      int unsigned k;
      bit          escaped;
      r_idx  = row;
      c_idx  = col;
      step_r = cfg_real_step;
      step_i = cfg_imag_step;
      if (r_idx >= INDEX_LIMIT) r_idx = INDEX_LIMIT - 1;
      if (c_idx >= INDEX_LIMIT) c_idx = INDEX_LIMIT - 1;
      cr = c_idx * step_r - FX_TWO;
      ci = FX_TWO - r_idx * step_i;
      zr = 0;
      zi = 0;
      k  = 0;
      do begin
         nr = fx_mul(zr, zr) - fx_mul(zi, zi) + cr;
         ni = fx_mul(2 * zr, zi) + ci;
         zr = nr;
         zi = ni;
         k++;
         // a coordinate of magnitude two or more always escapes
         if (fx_abs(zr) >= FX_TWO || fx_abs(zi) >= FX_TWO)
            escaped = 1'b1;
         else
            escaped = (fx_mul(zr, zr) + fx_mul(zi, zi)) >= FX_FOUR;
      end while (!escaped && k < cfg_max_iter);
      return (k >= cfg_max_iter) ? '0 : ITER_W'(k);
   endfunction

   function automatic int unsigned idle_cycles(input bit quiet);
      if (quiet || $urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 16);
   endfunction

   // called at a falling edge, returns at a falling edge with valid still high
   task automatic send_pixel(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                             input logic typed, input logic [ITER_W-1:0] count);
      int unsigned gap;
      gap = idle_cycles(req_quiet);
      if (gap != 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     = 1'b1;
      req_row_index = row;
      req_col_index = col;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      escape_q.push_back(typed ? count : predict_escape(row, col));
      sent_count++;
      @(negedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DAT_W-1:0] data);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_wdata = data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_MAX_ITER:  cfg_max_iter  = data[ITER_W-1:0];
         CSR_REAL_STEP: cfg_real_step = data[STEP_W-1:0];
         CSR_IMAG_STEP: cfg_imag_step = data[STEP_W-1:0];
         default: ;   // unmapped, dropped by the block
      endcase
      @(negedge clock);
   endtask

   // stop requesting and wait for every outstanding count
   task automatic drain_pixels();
      req_valid = 1'b0;
      while (escape_q.size() != 0) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic pick_step(output logic [CSR_DAT_W-1:0] data, output int unsigned span);
      case ($urandom_range(0, 11))
         0: begin data = '0;            span = INDEX_LIMIT; end
         1: begin data = 32'h1FFF_FFFF; span = INDEX_LIMIT; end
         2: begin data = 32'h1000_0000; span = INDEX_LIMIT; end
         3: begin data = $urandom();    span = INDEX_LIMIT; end
         default: begin
            // grid of span points across the width-four view
            span = $urandom_range(8, INDEX_LIMIT);
            data = (32'd1 << (FRAC_BITS + 2)) / span;
         end
      endcase
   endtask

   function automatic logic [ITER_W-1:0] pick_limit();
      case ($urandom_range(0, 9))
         0:       return ITER_W'($urandom_range(0, 1));
         1:       return ITER_W'($urandom_range(301, 1023));
         2, 3:    return ITER_W'($urandom_range(41, 300));
         default: return ITER_W'($urandom_range(2, 40));
      endcase
   endfunction

   // response side: random hold-off before each count
   initial begin
      int unsigned hold;
      rsp_stall = 1'b0;
      wait (reset === 1'b0);
      @(negedge clock);
      forever begin
         hold = idle_cycles(rsp_quiet);
         if (hold != 0) begin
            rsp_stall = 1'b1;
            repeat (hold) @(negedge clock);
         end
         rsp_stall = 1'b0;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (escape_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("ERROR: unexpected escape count %0d with no request pending",
                        rsp_escape_count);
         end else begin
            if (rsp_escape_count !== escape_q[0]) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("ERROR: result %0d escape_count expected %0d got %0d",
                           checked_count, escape_q[0], rsp_escape_count);
            end
            void'(escape_q.pop_front());
            checked_count++;
         end
      end
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("ERROR: timeout after %0d cycles, %0d counts outstanding",
               cycle_count, escape_q.size());
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int unsigned          idx;
      int unsigned          span_r;
      int unsigned          span_i;
      int unsigned          phase_items;
      logic [CSR_DAT_W-1:0] rstep_w;
      logic [CSR_DAT_W-1:0] istep_w;
      logic [IDX_W-1:0]     row;
      logic [IDX_W-1:0]     col;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_row_index = '0;
      req_col_index = '0;
      csr_valid     = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (idx = 0; idx < NUM_DIRECTED; idx++) begin
         if (DIRECTED[idx].limit != cfg_max_iter) begin
            drain_pixels();
            write_reg(CSR_MAX_ITER, CSR_DAT_W'(DIRECTED[idx].limit));
            csr_valid = 1'b0;
         end
         send_pixel(DIRECTED[idx].row, DIRECTED[idx].col,
                    DIRECTED[idx].typed, DIRECTED[idx].count);
      end

      while (sent_count < NUM_DIRECTED + RANDOM_ITEMS) begin
         drain_pixels();
         pick_step(rstep_w, span_r);
         pick_step(istep_w, span_i);
         write_reg(CSR_MAX_ITER, {16'($urandom_range(0, 65535)), pick_limit()});
         write_reg(CSR_REAL_STEP, rstep_w);
         write_reg(CSR_IMAG_STEP, istep_w);
         if (phase_count == 0 || $urandom_range(0, 4) == 0)
            write_reg(CSR_UNUSED, $urandom());
         csr_valid = 1'b0;
         req_quiet   = ($urandom_range(0, 3) == 0);
         rsp_quiet   = ($urandom_range(0, 3) == 0);
         // long limits are slow, keep those phases short
         phase_items = (cfg_max_iter > 300) ? 8 : $urandom_range(20, 100);
         repeat (phase_items) begin
            if ($urandom_range(0, 6) == 0) begin
               row = IDX_W'($urandom());
               col = IDX_W'($urandom());
            end else begin
               row = IDX_W'($urandom_range(0, span_i - 1));
               col = IDX_W'($urandom_range(0, span_r - 1));
            end
            send_pixel(row, col, 1'b0, '0);
         end
         phase_count++;
      end

      drain_pixels();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Checked %0d escape counts from %0d pixel requests in %0d cycles",
               checked_count, sent_count, cycle_count);
      $display("Covered limits 0 to 65535 and %0d random register settings",
               phase_count);
      if (mismatch_count == 0 && escape_q.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d mismatches, %0d counts outstanding", mismatch_count,
                  escape_q.size());
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
